>>> hw/rtl/sparse_gradient_hessian_accumulator_unit_defines.svh
// Assertion macros used by the accumulator controller.
`ifndef SPARSE_GRADIENT_HESSIAN_ACCUMULATOR_UNIT_DEFINES_SVH
`define SPARSE_GRADIENT_HESSIAN_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define SGHA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define SGHA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sgha_pkg.sv
// Shared types, constants and helpers of the gradient/hessian accumulator.
`default_nettype none

package sgha_pkg;

   // Label store depth and the address width that follows from it.
   localparam int NUM_LABELS = 256;
   localparam int ADDR_W     = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;

   localparam int CMD_W    = 3;
   localparam int LABEL_W  = 8;
   localparam int VALUE_W  = 32;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W    = 48;
   localparam int WSUM_W   = 32;
   localparam int PROD_W   = 48;
   localparam int ROUND_SH = 8;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD     = 3'd0,
      CMD_SUB     = 3'd1,
      CMD_ROW_IN  = 3'd2,
      CMD_ROW_OUT = 3'd3,
      CMD_CLEAR   = 3'd4,
      CMD_READ    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE
   } state_type;

   // One row of the label store.
   typedef struct packed {
      logic [SUM_W-1:0]  gradient;
      logic [SUM_W-1:0]  hessian;
      logic [WSUM_W-1:0] weight;
   } entry_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;    // capture the accepted beat
      logic fetch;   // read the store, form the products
      logic commit;  // write back, load the result register
   } ctrl_cmd_type;

   // Map a label onto a store address.
   function automatic addr_type label_to_addr(input logic [LABEL_W-1:0] label);
      return addr_type'(label);
   endfunction

   // Label lies inside the store.
   function automatic logic label_in_range(input logic [LABEL_W-1:0] label);
      return 32'(label) < 32'(NUM_LABELS);
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sgha_ctrl.sv
// Controller state machine: handshakes, sequencing and result valid.
`default_nettype none
`include "sparse_gradient_hessian_accumulator_unit_defines.svh"

module sgha_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      sgha_pkg::ctrl_cmd_type cmd
);

   sgha_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_blocked;

   assign out_blocked = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgha_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         sgha_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sgha_pkg::ST_FETCH;
            end
         end
         sgha_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = sgha_pkg::ST_UPDATE;
         end
         sgha_pkg::ST_UPDATE: begin
            // hold the update until the result register is free
            if (!out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = sgha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgha_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SGHA_ASSERT_IMPLIES(a_commit_free, cmd.commit, !(rsp_valid_ff && rsp_stall), "commit over held result")
   `SGHA_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_ff, "commit without result valid")
   `SGHA_ASSERT_NEXT(a_load_fetch, cmd.load, cmd.fetch, "accepted beat not fetched next cycle")
   `SGHA_ASSERT_IMPLIES(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.fetch, cmd.commit}), "commands overlap")

endmodule

`default_nettype wire

>>> hw/rtl/sgha_dp.sv
// Datapath: item registers, label store, multipliers, accumulators, result register.
`default_nettype none

module sgha_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire sgha_pkg::ctrl_cmd_type                 cmd,
   input  wire logic [sgha_pkg::CMD_W-1:0]             req_command,
   input  wire logic [sgha_pkg::LABEL_W-1:0]           req_label_index,
   input  wire logic signed [sgha_pkg::VALUE_W-1:0]    req_entry_gradient,
   input  wire logic signed [sgha_pkg::VALUE_W-1:0]    req_entry_hessian,
   input  wire logic [sgha_pkg::WEIGHT_W-1:0]          req_entry_weight,
   output      logic signed [sgha_pkg::SUM_W-1:0]      rsp_sum_gradient,
   output      logic signed [sgha_pkg::SUM_W-1:0]      rsp_sum_hessian,
   output      logic signed [sgha_pkg::WSUM_W-1:0]     rsp_sum_weight,
   output      logic signed [sgha_pkg::WSUM_W-1:0]     rsp_total_weight
);

   // Captured beat
   logic [sgha_pkg::CMD_W-1:0]          cmd_ff;
   logic [sgha_pkg::LABEL_W-1:0]        label_ff;
   logic signed [sgha_pkg::VALUE_W-1:0] grad_ff, hess_ff;
   logic [sgha_pkg::WEIGHT_W-1:0]       weight_ff;

   // Label store and its valid bits
   sgha_pkg::entry_type                 mem [sgha_pkg::NUM_LABELS];
   logic [sgha_pkg::NUM_LABELS-1:0]     valid_ff;
   sgha_pkg::entry_type                 rd_ff;
   logic                                rd_valid_ff;

   // Products
   logic signed [sgha_pkg::WEIGHT_W:0]   weight_s;
   logic signed [sgha_pkg::PROD_W:0]     prod_g_full, prod_h_full;
   logic signed [sgha_pkg::PROD_W-1:0]   prod_g_ff, prod_h_ff;
   logic signed [sgha_pkg::PROD_W-1:0]   rnd_g, rnd_h;
   logic [sgha_pkg::SUM_W-1:0]           term_g, term_h;

   logic [sgha_pkg::WSUM_W-1:0]          total_ff, total_in;
   sgha_pkg::addr_type                   addr;
   logic                                 label_ok, is_entry, entry_en, is_clear;
   sgha_pkg::entry_type                  cur, upd;

   logic signed [sgha_pkg::SUM_W-1:0]    out_g_ff, out_h_ff;
   logic signed [sgha_pkg::WSUM_W-1:0]   out_w_ff, out_t_ff;

   assign addr     = sgha_pkg::label_to_addr(label_ff);
   assign label_ok = sgha_pkg::label_in_range(label_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_command;
         label_ff  <= req_label_index;
         grad_ff   <= req_entry_gradient;
         hess_ff   <= req_entry_hessian;
         weight_ff <= req_entry_weight;
      end
   end

   // Q16.16 times Q8.8, exact Q24.24
   assign weight_s    = $signed({1'b0, weight_ff});
   assign prod_g_full = (sgha_pkg::PROD_W+1)'(grad_ff) * (sgha_pkg::PROD_W+1)'(weight_s);
   assign prod_h_full = (sgha_pkg::PROD_W+1)'(hess_ff) * (sgha_pkg::PROD_W+1)'(weight_s);

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         prod_g_ff <= prod_g_full[sgha_pkg::PROD_W-1:0];
         prod_h_ff <= prod_h_full[sgha_pkg::PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_ff <= mem[addr];
      end
      if (cmd.commit && entry_en) begin
         mem[addr] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.fetch) begin
            rd_valid_ff <= valid_ff[addr];
         end
         if (cmd.commit && is_clear) begin
            valid_ff <= '0;
         end else if (cmd.commit && entry_en) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   // Round to Q24.16: add half an LSB, shift with sign kept
   assign rnd_g  = prod_g_ff + sgha_pkg::PROD_W'(128);
   assign rnd_h  = prod_h_ff + sgha_pkg::PROD_W'(128);
   assign term_g = {{sgha_pkg::ROUND_SH{rnd_g[sgha_pkg::PROD_W-1]}},
                    rnd_g[sgha_pkg::PROD_W-1:sgha_pkg::ROUND_SH]};
   assign term_h = {{sgha_pkg::ROUND_SH{rnd_h[sgha_pkg::PROD_W-1]}},
                    rnd_h[sgha_pkg::PROD_W-1:sgha_pkg::ROUND_SH]};

   assign is_entry = (cmd_ff == sgha_pkg::CMD_ADD) || (cmd_ff == sgha_pkg::CMD_SUB);
   assign is_clear = (cmd_ff == sgha_pkg::CMD_CLEAR);
   assign entry_en = is_entry && label_ok && (weight_ff != '0);
   assign cur      = rd_valid_ff ? rd_ff : '0;

   always_comb begin
      upd      = cur;
      total_in = total_ff;
      case (cmd_ff)
         sgha_pkg::CMD_ADD: begin
            if (entry_en) begin
               upd.gradient = cur.gradient + term_g;
               upd.hessian  = cur.hessian + term_h;
               upd.weight   = cur.weight + sgha_pkg::WSUM_W'(weight_ff);
            end
         end
         sgha_pkg::CMD_SUB: begin
            if (entry_en) begin
               upd.gradient = cur.gradient - term_g;
               upd.hessian  = cur.hessian - term_h;
               upd.weight   = cur.weight - sgha_pkg::WSUM_W'(weight_ff);
            end
         end
         sgha_pkg::CMD_ROW_IN: begin
            total_in = total_ff + sgha_pkg::WSUM_W'(weight_ff);
         end
         sgha_pkg::CMD_ROW_OUT: begin
            total_in = total_ff - sgha_pkg::WSUM_W'(weight_ff);
         end
         sgha_pkg::CMD_CLEAR: begin
            upd      = '0;
            total_in = '0;
         end
         default: begin
            upd = cur;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.commit) begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_g_ff <= label_ok ? $signed(upd.gradient) : '0;
         out_h_ff <= label_ok ? $signed(upd.hessian) : '0;
         out_w_ff <= label_ok ? $signed(upd.weight) : '0;
         out_t_ff <= $signed(total_in);
      end
   end

   assign rsp_sum_gradient = out_g_ff;
   assign rsp_sum_hessian  = out_h_ff;
   assign rsp_sum_weight   = out_w_ff;
   assign rsp_total_weight = out_t_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sparse_gradient_hessian_accumulator_unit.sv
// Top level of the sparse gradient/hessian accumulator.
//
//   channel | direction | handshake          | beat contents
//   --------+-----------+--------------------+-------------------------------------------
//   req     | in        | req_valid/req_stall| command, label, gradient, hessian, weight
//   rsp     | out       | rsp_valid/rsp_stall| label sums after update, row weight total
//
// An item goes through accept, store read plus multiply, then update and write back;
// the read-modify-write of the single-port label store sets this sequence.
// The next item is accepted the cycle after write back, while the result may still wait.
// A stalled result holds the update step until the result register frees up.
// Reset clears the label valid bits and the row total at once; clear does the same in
// its update cycle, so neither walks the store.
`default_nettype none

module sparse_gradient_hessian_accumulator_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic [sgha_pkg::CMD_W-1:0]             req_command,
   input  wire logic [sgha_pkg::LABEL_W-1:0]           req_label_index,
   input  wire logic signed [sgha_pkg::VALUE_W-1:0]    req_entry_gradient,
   input  wire logic signed [sgha_pkg::VALUE_W-1:0]    req_entry_hessian,
   input  wire logic [sgha_pkg::WEIGHT_W-1:0]          req_entry_weight,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic signed [sgha_pkg::SUM_W-1:0]      rsp_sum_gradient,
   output      logic signed [sgha_pkg::SUM_W-1:0]      rsp_sum_hessian,
   output      logic signed [sgha_pkg::WSUM_W-1:0]     rsp_sum_weight,
   output      logic signed [sgha_pkg::WSUM_W-1:0]     rsp_total_weight
);

   // Commands from the sequencer to the datapath
   sgha_pkg::ctrl_cmd_type cmd;

   // Sequence accept, fetch and update; own the result valid
   sgha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Hold the beat, the label store, the products and the result register
   sgha_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_command        (req_command),
      .req_label_index    (req_label_index),
      .req_entry_gradient (req_entry_gradient),
      .req_entry_hessian  (req_entry_hessian),
      .req_entry_weight   (req_entry_weight),
      .rsp_sum_gradient   (rsp_sum_gradient),
      .rsp_sum_hessian    (rsp_sum_hessian),
      .rsp_sum_weight     (rsp_sum_weight),
      .rsp_total_weight   (rsp_total_weight)
   );

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench of the sparse gradient/hessian accumulator unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Command codes the block does not name; it treats them as a read.
   localparam logic [sgha_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [sgha_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_PERCENT  = 10;
   localparam int DIRECTED_ROWS = 23;
   localparam int GAPPY_ITEMS   = 500;   // random beats of the first phase with idling
   localparam int STEADY_ITEMS  = 400;   // random beats with no idling at all
   localparam int TAIL_ITEMS    = 480;
   localparam int SETTLE_CYCLES = 16;    // wait past the last result for a stray extra beat

   // Sums of one label after an update, plus the row weight total.
   typedef struct packed {
      logic [sgha_pkg::SUM_W-1:0]  gradient;
      logic [sgha_pkg::SUM_W-1:0]  hessian;
      logic [sgha_pkg::WSUM_W-1:0] weight;
      logic [sgha_pkg::WSUM_W-1:0] total;
   } label_sums_type;

   // One request beat; typed_in marks rows whose sums are written out by hand.
   typedef struct packed {
      logic [sgha_pkg::CMD_W-1:0]    command;
      logic [sgha_pkg::LABEL_W-1:0]  label;
      logic [sgha_pkg::VALUE_W-1:0]  gradient;
      logic [sgha_pkg::VALUE_W-1:0]  hessian;
      logic [sgha_pkg::WEIGHT_W-1:0] weight;
      logic                          typed_in;
      label_sums_type                sums;
   } stim_row_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [sgha_pkg::CMD_W-1:0]            req_command = '0;
   logic [sgha_pkg::LABEL_W-1:0]          req_label_index = '0;
   logic signed [sgha_pkg::VALUE_W-1:0]   req_entry_gradient = '0;
   logic signed [sgha_pkg::VALUE_W-1:0]   req_entry_hessian = '0;
   logic [sgha_pkg::WEIGHT_W-1:0]         req_entry_weight = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [sgha_pkg::SUM_W-1:0]     rsp_sum_gradient;
   logic signed [sgha_pkg::SUM_W-1:0]     rsp_sum_hessian;
   logic signed [sgha_pkg::WSUM_W-1:0]    rsp_sum_weight;
   logic signed [sgha_pkg::WSUM_W-1:0]    rsp_total_weight;

   // Shadow copy of the label store and the row total.
   logic [sgha_pkg::SUM_W-1:0]  gradient_acc [sgha_pkg::NUM_LABELS];
   logic [sgha_pkg::SUM_W-1:0]  hessian_acc  [sgha_pkg::NUM_LABELS];
   logic [sgha_pkg::WSUM_W-1:0] weight_acc   [sgha_pkg::NUM_LABELS];
   logic [sgha_pkg::WSUM_W-1:0] row_total;

   label_sums_type expected_sums [$];
   stim_row_type   directed_rows [DIRECTED_ROWS];
   int             mismatch_count = 0;
   bit             gaps_on = 1'b1;   // both sides idle at random while set

   sparse_gradient_hessian_accumulator_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_label_index    (req_label_index),
      .req_entry_gradient (req_entry_gradient),
      .req_entry_hessian  (req_entry_hessian),
      .req_entry_weight   (req_entry_weight),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sum_gradient   (rsp_sum_gradient),
      .rsp_sum_hessian    (rsp_sum_hessian),
      .rsp_sum_weight     (rsp_sum_weight),
      .rsp_total_weight   (rsp_total_weight)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Q16.16 value times Q8.8 weight is exact Q24.24; add half an LSB of Q24.16
   // and drop eight bits with the sign kept, so ties round toward plus infinity.
   function automatic logic [sgha_pkg::SUM_W-1:0] weighted_term(
         input logic [sgha_pkg::VALUE_W-1:0] value,
         input logic [sgha_pkg::WEIGHT_W-1:0] weight);
      logic signed [63:0] product;
      product = 64'($signed(value)) * 64'($signed({1'b0, weight}));
      product = product + 64'sd128;
      return product[sgha_pkg::SUM_W+7:8];
   endfunction

   // Apply one accepted beat to the shadow store and return the sums it reports.
   function automatic label_sums_type accumulate_beat(input stim_row_type row);
      label_sums_type sums;
      bit             in_store;
      in_store = int'(row.label) < sgha_pkg::NUM_LABELS;
      case (row.command)
         sgha_pkg::CMD_ADD, sgha_pkg::CMD_SUB: begin
            // A zero weight or a label past the store leaves every sum alone.
            if (in_store && row.weight != '0) begin
               if (row.command == sgha_pkg::CMD_ADD) begin
                  gradient_acc[row.label] += weighted_term(row.gradient, row.weight);
                  hessian_acc[row.label]  += weighted_term(row.hessian, row.weight);
                  weight_acc[row.label]   += sgha_pkg::WSUM_W'(row.weight);
               end else begin
                  gradient_acc[row.label] -= weighted_term(row.gradient, row.weight);
                  hessian_acc[row.label]  -= weighted_term(row.hessian, row.weight);
                  weight_acc[row.label]   -= sgha_pkg::WSUM_W'(row.weight);
               end
            end
         end
         sgha_pkg::CMD_ROW_IN:  row_total += sgha_pkg::WSUM_W'(row.weight);
         sgha_pkg::CMD_ROW_OUT: row_total -= sgha_pkg::WSUM_W'(row.weight);
         sgha_pkg::CMD_CLEAR: begin
            foreach (gradient_acc[i]) begin
               gradient_acc[i] = '0;
               hessian_acc[i]  = '0;
               weight_acc[i]   = '0;
            end
            row_total = '0;
         end
         default: ;   // read and the spare codes change nothing
      endcase
      sums = '0;
      if (in_store) begin
         sums.gradient = gradient_acc[row.label];
         sums.hessian  = hessian_acc[row.label];
         sums.weight   = weight_acc[row.label];
      end
      sums.total = row_total;
      return sums;
   endfunction

   // Send one beat: maybe idle first, then hold the payload until the block takes
   // it. Entered and left just after a falling edge.
   task automatic push_beat(input stim_row_type row);
      int gap;
      gap = (gaps_on && $urandom_range(99) < IDLE_PERCENT) ? $urandom_range(1, 4) : 0;
      repeat (gap) begin
         // Scramble the payload while valid is low; the block must ignore it.
         req_valid          <= 1'b0;
         req_command        <= sgha_pkg::CMD_W'($urandom);
         req_label_index    <= sgha_pkg::LABEL_W'($urandom);
         req_entry_gradient <= $urandom;
         req_entry_hessian  <= $urandom;
         req_entry_weight   <= sgha_pkg::WEIGHT_W'($urandom);
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= row.command;
      req_label_index    <= row.label;
      req_entry_gradient <= row.gradient;
      req_entry_hessian  <= row.hessian;
      req_entry_weight   <= row.weight;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Beat accepted at this edge: advance the shadow store in step with it.
      if (row.typed_in) begin
         void'(accumulate_beat(row));
         expected_sums.push_back(row.sums);
      end else begin
         expected_sums.push_back(accumulate_beat(row));
      end
      @(negedge clock);
   endtask

   function automatic logic [sgha_pkg::VALUE_W-1:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (pick < 25) return sgha_pkg::VALUE_W'($signed($urandom_range(1023)) - 512);
      return $urandom;
   endfunction

   // Mostly entries on a handful of hot labels, so back-to-back beats hit the
   // same store row; rows, reads, clears and spare codes mixed in.
   task automatic push_random_beat();
      stim_row_type row;
      int           pick;
      row  = '0;
      pick = $urandom_range(99);
      if (pick < 40)      row.command = sgha_pkg::CMD_ADD;
      else if (pick < 65) row.command = sgha_pkg::CMD_SUB;
      else if (pick < 75) row.command = sgha_pkg::CMD_ROW_IN;
      else if (pick < 85) row.command = sgha_pkg::CMD_ROW_OUT;
      else if (pick < 87) row.command = sgha_pkg::CMD_CLEAR;
      else if (pick < 96) row.command = sgha_pkg::CMD_READ;
      else                row.command = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      row.label    = ($urandom_range(99) < 60) ? sgha_pkg::LABEL_W'($urandom_range(3))
                                               : sgha_pkg::LABEL_W'($urandom_range(255));
      row.gradient = random_value();
      row.hessian  = random_value();
      pick = $urandom_range(99);
      if (pick < 10)      row.weight = '0;
      else if (pick < 30) row.weight = 16'h0100;
      else if (pick < 40) row.weight = 16'hFFFF;
      else                row.weight = sgha_pkg::WEIGHT_W'($urandom_range(16'hFFFF));
      push_beat(row);
   endtask

   // Result side stalls at random, changed only on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= !reset && gaps_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Compare every result beat with the oldest outstanding prediction.
   always @(posedge clock) begin : sums_check
      label_sums_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $error("result beat with nothing outstanding: %h %h %h %h", rsp_sum_gradient,
                   rsp_sum_hessian, rsp_sum_weight, rsp_total_weight);
            mismatch_count++;
         end else begin
            want = expected_sums.pop_front();
            if (rsp_sum_gradient !== want.gradient) begin
               $error("sum_gradient: expected %h, actual %h", want.gradient, rsp_sum_gradient);
               mismatch_count++;
            end
            if (rsp_sum_hessian !== want.hessian) begin
               $error("sum_hessian: expected %h, actual %h", want.hessian, rsp_sum_hessian);
               mismatch_count++;
            end
            if (rsp_sum_weight !== want.weight) begin
               $error("sum_weight: expected %h, actual %h", want.weight, rsp_sum_weight);
               mismatch_count++;
            end
            if (rsp_total_weight !== want.total) begin
               $error("total_weight: expected %h, actual %h", want.total, rsp_total_weight);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      foreach (gradient_acc[i]) begin
         gradient_acc[i] = '0;
         hessian_acc[i]  = '0;
         weight_acc[i]   = '0;
      end
      row_total = '0;

      // command, label, gradient, hessian, weight, typed_in, sums
      directed_rows = '{
         // fresh store reads back zero at both ends of the label range
         '{sgha_pkg::CMD_READ,    8'd0,   32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, '0},
         '{sgha_pkg::CMD_READ,    8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '0},
         // unweighted add of 1.0 and 2.0
         '{sgha_pkg::CMD_ADD,     8'd3,   32'h0001_0000, 32'h0002_0000, 16'h0100, 1'b1,
           '{48'h1_0000, 48'h2_0000, 32'h100, 32'h0}},
         // zero weight changes nothing
         '{sgha_pkg::CMD_ADD,     8'd3,   32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b1,
           '{48'h1_0000, 48'h2_0000, 32'h100, 32'h0}},
         // largest magnitudes, then take them straight back out
         '{sgha_pkg::CMD_ADD,     8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0, '0},
         '{sgha_pkg::CMD_SUB,     8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1, '0},
         // rounding: below half, exactly half, just under half, both signs
         '{sgha_pkg::CMD_SUB,     8'd7,   32'h0000_0001, 32'hFFFF_FFFF, 16'h0001, 1'b0, '0},
         '{sgha_pkg::CMD_ADD,     8'd7,   32'h0000_0080, 32'hFFFF_FF80, 16'h0001, 1'b0, '0},
         '{sgha_pkg::CMD_ADD,     8'd7,   32'h0000_007F, 32'hFFFF_FF7F, 16'h0001, 1'b0, '0},
         // row commands leave the label sums alone
         '{sgha_pkg::CMD_ROW_IN,  8'd3,   32'h1234_5678, 32'h9ABC_DEF0, 16'hFFFF, 1'b1,
           '{48'h1_0000, 48'h2_0000, 32'h100, 32'hFFFF}},
         '{sgha_pkg::CMD_ROW_IN,  8'd0,   32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0, '0},
         '{sgha_pkg::CMD_ROW_OUT, 8'd255, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b0, '0},
         '{sgha_pkg::CMD_ROW_OUT, 8'd255, 32'h0000_0000, 32'h0000_0000, 16'h0001, 1'b0, '0},
         // spare codes behave as a read
         '{CMD_SPARE_LO,          8'd3,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
         '{CMD_SPARE_HI,          8'd7,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
         // back-to-back beats on one label, the gradient sum goes negative
         '{sgha_pkg::CMD_ADD,     8'd0,   32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, '0},
         '{sgha_pkg::CMD_ADD,     8'd0,   32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, '0},
         '{sgha_pkg::CMD_SUB,     8'd0,   32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, '0},
         '{sgha_pkg::CMD_ADD,     8'd1,   32'h0001_0000, 32'h0001_0000, 16'hFFFF, 1'b0, '0},
         // clear zeroes every label and the total
         '{sgha_pkg::CMD_CLEAR,   8'd3,   32'hDEAD_BEEF, 32'hCAFE_F00D, 16'hFFFF, 1'b1, '0},
         '{sgha_pkg::CMD_READ,    8'd255, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, '0},
         '{sgha_pkg::CMD_ROW_IN,  8'd1,   32'h0000_0000, 32'h0000_0000, 16'h0100, 1'b1,
           '{48'h0, 48'h0, 32'h0, 32'h100}},
         '{sgha_pkg::CMD_ADD,     8'd2,   32'h1234_5678, 32'hEDCB_A988, 16'h0180, 1'b0, '0}
      };

      // Hold reset, then release it on a falling edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) push_beat(directed_rows[i]);
      repeat (GAPPY_ITEMS) push_random_beat();

      // Drop valid and hold off until every outstanding result is back.
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_sums.size() != 0);

      // Long stretch at full rate on both sides.
      gaps_on = 1'b0;
      repeat (STEADY_ITEMS) push_random_beat();
      gaps_on = 1'b1;
      repeat (TAIL_ITEMS) push_random_beat();

      // Drain, then give a stray extra result time to show up.
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_sums.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
